// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the aggregator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define PSTA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the module's clk_i / rst_ni
`define PSTA_ASSERT(lbl, prop, msg) \
  `PSTA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/psta_pkg.sv -----
// ----------------------------------------------------------------------------
// psta_pkg
// Types and constants of the per-symbol tick aggregator.
// ----------------------------------------------------------------------------
package psta_pkg;

  localparam int KeyW   = 64;
  localparam int PriceW = 32;
  localparam int VolW   = 32;
  localparam int ProdW  = 64;
  localparam int PvW    = 63;
  localparam int VsumW  = 48;
  localparam int CntW   = 32;
  localparam int RecW   = 32;
  localparam int SlotW  = 6;

  localparam int TableEntriesDef = 64;

  localparam logic [PvW-1:0]   PvMax   = {PvW{1'b1}};
  localparam logic [VsumW-1:0] VsumMax = {VsumW{1'b1}};
  localparam logic [CntW-1:0]  CntMax  = {CntW{1'b1}};
  localparam logic [RecW-1:0]  RecMax  = {RecW{1'b1}};

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_CREATED = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  // word travelling down the cell chain
  typedef struct packed {
    logic              vld;
    logic              done;
    logic [KeyW-1:0]   key;
    logic [PriceW-1:0] price;
    logic [VolW-1:0]   vol;
    logic [ProdW-1:0]  prod;
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [PvW-1:0]    pv;
    logic [VsumW-1:0]  vsum;
    logic [CntW-1:0]   cnt;
    logic [PriceW-1:0] hi;
    logic [PriceW-1:0] lo;
    logic              sat;
  } word_t;

endpackage

// ----- rtl/psta_cell.sv -----
// ----------------------------------------------------------------------------
// psta_cell
// One table entry: matches or claims the passing word, updates its sums.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psta_cell #(
  parameter int CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  psta_pkg::word_t word_i,
  output psta_pkg::word_t word_o,
  output logic            ent_vld_o
);
  import psta_pkg::*;

  logic              valid_q;
  logic [KeyW-1:0]   key_q;
  logic [PvW-1:0]    pv_q;
  logic [VsumW-1:0]  vsum_q;
  logic [CntW-1:0]   cnt_q;
  logic [PriceW-1:0] hi_q;
  logic [PriceW-1:0] lo_q;
  word_t             word_q;
  word_t             word_d;

  logic              open_w;
  logic              hit;
  logic              claim;
  logic [PvW-1:0]    base_pv;
  logic [VsumW-1:0]  base_vsum;
  logic [CntW-1:0]   base_cnt;
  logic [PriceW-1:0] base_hi;
  logic [PriceW-1:0] base_lo;
  logic [PvW+1:0]    pv_sum;
  logic [VsumW:0]    vsum_sum;
  logic [PvW-1:0]    new_pv;
  logic [VsumW-1:0]  new_vsum;
  logic [CntW-1:0]   new_cnt;
  logic [PriceW-1:0] new_hi;
  logic [PriceW-1:0] new_lo;

  assign open_w = word_i.vld && !word_i.done;
  assign hit    = open_w && valid_q && (key_q == word_i.key);
  assign claim  = open_w && !valid_q;

  always_comb begin
    base_pv   = claim ? '0 : pv_q;
    base_vsum = claim ? '0 : vsum_q;
    base_cnt  = claim ? '0 : cnt_q;
    base_hi   = claim ? word_i.price : hi_q;
    base_lo   = claim ? word_i.price : lo_q;

    pv_sum   = {2'b00, base_pv} + {1'b0, word_i.prod};
    vsum_sum = {1'b0, base_vsum} + {{(VsumW+1-VolW){1'b0}}, word_i.vol};
    new_pv   = (pv_sum >= {2'b00, PvMax}) ? PvMax : pv_sum[PvW-1:0];
    new_vsum = (vsum_sum >= {1'b0, VsumMax}) ? VsumMax : vsum_sum[VsumW-1:0];
    new_cnt  = (base_cnt == CntMax) ? CntMax : base_cnt + CntW'(1);
    new_hi   = (word_i.price > base_hi) ? word_i.price : base_hi;
    new_lo   = (word_i.price < base_lo) ? word_i.price : base_lo;
  end

  always_comb begin
    word_d = word_i;
    if (hit || claim) begin
      word_d.done   = 1'b1;
      word_d.status = claim ? ST_CREATED : ST_UPDATED;
      word_d.slot   = SlotW'(CellIdx);
      word_d.pv     = new_pv;
      word_d.vsum   = new_vsum;
      word_d.cnt    = new_cnt;
      word_d.hi     = new_hi;
      word_d.lo     = new_lo;
      word_d.sat    = (new_pv == PvMax) || (new_vsum == VsumMax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      word_q  <= '0;
    end else if (adv_i) begin
      word_q <= word_d;
      if (claim) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && (hit || claim)) begin
      key_q  <= word_i.key;
      pv_q   <= new_pv;
      vsum_q <= new_vsum;
      cnt_q  <= new_cnt;
      hi_q   <= new_hi;
      lo_q   <= new_lo;
    end
  end

  assign word_o    = word_q;
  assign ent_vld_o = valid_q;

  `PSTA_ASSERT(a_entry_sticky, valid_q |=> valid_q, "table entry lost its valid mark")
  `PSTA_ASSERT(a_claim_done, (adv_i && claim) |=> (valid_q && word_q.done && (word_q.status == ST_CREATED)), "claimed entry not reported")

endmodule

// ----- rtl/per_symbol_tick_aggregator_unit.sv -----
// A word passes the product stage, every table cell and the output register before result valid.
// Throughput: one word per cycle unless the output stalls; the word walks the entry chain one cell a cycle.
// The product stage, every cell and the output register advance together; a
// stalled output holds the whole chain.
// Reset clears all entry valid marks, the record count and the output valid.
// ----------------------------------------------------------------------------
// per_symbol_tick_aggregator_unit
// Per-symbol VWAP sums, count and high/low over a chain of table cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_symbol_tick_aggregator_unit #(
  parameter int TABLE_ENTRIES = psta_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [psta_pkg::KeyW-1:0]     symbol_key_i,
  input  logic [psta_pkg::PriceW-1:0]   price_ticks_i,
  input  logic [psta_pkg::VolW-1:0]     trade_volume_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [psta_pkg::SlotW-1:0]    slot_o,
  output logic [psta_pkg::PvW-1:0]      price_volume_sum_o,
  output logic [psta_pkg::VsumW-1:0]    volume_sum_o,
  output logic [psta_pkg::CntW-1:0]     tick_count_o,
  output logic [psta_pkg::PriceW-1:0]   high_price_o,
  output logic [psta_pkg::PriceW-1:0]   low_price_o,
  output logic [psta_pkg::RecW-1:0]     records_total_o,
  output logic                          sum_saturated_o
);
  import psta_pkg::*;

  logic                     adv;
  word_t                    s0_q;
  word_t                    s0_d;
  word_t                    chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] ent_vld;
  word_t                    tail;

  logic                     out_vld_q;
  status_e                  status_q;
  logic [SlotW-1:0]         slot_q;
  logic [PvW-1:0]           pv_q;
  logic [VsumW-1:0]         vsum_q;
  logic [CntW-1:0]          cnt_q;
  logic [PriceW-1:0]        hi_q;
  logic [PriceW-1:0]        lo_q;
  logic                     sat_q;
  logic [RecW-1:0]          rec_q;
  logic [RecW-1:0]          rec_d;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // product stage
  always_comb begin
    s0_d       = '0;
    s0_d.vld   = in_valid_i;
    s0_d.key   = symbol_key_i;
    s0_d.price = price_ticks_i;
    s0_d.vol   = trade_volume_i;
    s0_d.prod  = ProdW'(price_ticks_i) * ProdW'(trade_volume_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (adv) begin
      s0_q <= s0_d;
    end
  end

  assign chain[0] = s0_q;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    psta_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .word_i   (chain[i]),
      .word_o   (chain[i+1]),
      .ent_vld_o(ent_vld[i])
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  always_comb begin
    rec_d = rec_q;
    if (tail.vld && tail.done && (rec_q != RecMax)) begin
      rec_d = rec_q + RecW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      rec_q     <= '0;
    end else if (adv) begin
      out_vld_q <= tail.vld;
      rec_q     <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (tail.done) begin
        status_q <= tail.status;
        slot_q   <= tail.slot;
        pv_q     <= tail.pv;
        vsum_q   <= tail.vsum;
        cnt_q    <= tail.cnt;
        hi_q     <= tail.hi;
        lo_q     <= tail.lo;
        sat_q    <= tail.sat;
      end else begin
        status_q <= ST_DROPPED;
        slot_q   <= '0;
        pv_q     <= '0;
        vsum_q   <= '0;
        cnt_q    <= '0;
        hi_q     <= '0;
        lo_q     <= '0;
        sat_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o           = status_q;
  assign slot_o             = slot_q;
  assign price_volume_sum_o = pv_q;
  assign volume_sum_o       = vsum_q;
  assign tick_count_o       = cnt_q;
  assign high_price_o       = hi_q;
  assign low_price_o        = lo_q;
  assign records_total_o    = rec_q;
  assign sum_saturated_o    = sat_q;

  // entries fill lowest first and are never freed
  `PSTA_ASSERT(a_valid_prefix, ((ent_vld + TABLE_ENTRIES'(1)) & ent_vld) == '0, "valid entries not a prefix")
  `PSTA_ASSERT(a_drop_full, (out_vld_q && (status_q == ST_DROPPED)) |-> (&ent_vld), "drop with free entry")
  `PSTA_ASSERT(a_rec_step, (adv && tail.vld && tail.done) |=> ((rec_q == $past(rec_q) + RecW'(1)) || (rec_q == RecMax)), "record count not advanced")

endmodule

// ----- bench/tick_stats_checker.sv -----
// ----------------------------------------------------------------------------
// tick_stats_checker
// Watches both channels of the tick aggregator. Predicts each entry's sums,
// count, high/low and the global record count for every accepted word, and
// compares every result word field by field, in order, against the prediction.
// ----------------------------------------------------------------------------
module tick_stats_checker #(
  parameter int ENTRIES = psta_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [psta_pkg::KeyW-1:0]     symbol_key_i,
  input  logic [psta_pkg::PriceW-1:0]   price_ticks_i,
  input  logic [psta_pkg::VolW-1:0]     trade_volume_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    status_i,
  input  logic [psta_pkg::SlotW-1:0]    slot_i,
  input  logic [psta_pkg::PvW-1:0]      price_volume_sum_i,
  input  logic [psta_pkg::VsumW-1:0]    volume_sum_i,
  input  logic [psta_pkg::CntW-1:0]     tick_count_i,
  input  logic [psta_pkg::PriceW-1:0]   high_price_i,
  input  logic [psta_pkg::PriceW-1:0]   low_price_i,
  input  logic [psta_pkg::RecW-1:0]     records_total_i,
  input  logic                          sum_saturated_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import psta_pkg::*;

  localparam int PvWideW   = PvW + 2;
  localparam int VsumWideW = VsumW + 1;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [PvW-1:0]    pv;
    logic [VsumW-1:0]  vsum;
    logic [CntW-1:0]   cnt;
    logic [PriceW-1:0] hi;
    logic [PriceW-1:0] lo;
    logic [RecW-1:0]   rec;
    logic              sat;
  } tick_stats_t;

  logic              entry_valid [ENTRIES];
  logic [KeyW-1:0]   entry_key   [ENTRIES];
  logic [PvW-1:0]    entry_pv    [ENTRIES];
  logic [VsumW-1:0]  entry_vsum  [ENTRIES];
  logic [CntW-1:0]   entry_cnt   [ENTRIES];
  logic [PriceW-1:0] entry_hi    [ENTRIES];
  logic [PriceW-1:0] entry_lo    [ENTRIES];
  logic [RecW-1:0]   records;

  tick_stats_t expected_stats_q [$];

  function automatic tick_stats_t aggregate_tick(input logic [KeyW-1:0] key,
                                                 input logic [PriceW-1:0] price,
                                                 input logic [VolW-1:0] vol);
    int               i;
    int               hit;
    int               free_idx;
    logic [ProdW-1:0] prod;
    logic [PvWideW-1:0]   pv_wide;
    logic [VsumWideW-1:0] vsum_wide;
    tick_stats_t      r;
    hit = -1;
    free_idx = -1;
    r = '0;
    for (i = 0; i < ENTRIES; i++) begin
      if (entry_valid[i]) begin
        if (hit < 0 && entry_key[i] == key) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit < 0 && free_idx < 0) begin
      r.status = ST_DROPPED;
      r.rec = records;
      return r;
    end
    r.status = ST_UPDATED;
    if (hit < 0) begin
      hit = free_idx;
      r.status = ST_CREATED;
      entry_valid[hit] = 1'b1;
      entry_key[hit] = key;
      entry_pv[hit] = '0;
      entry_vsum[hit] = '0;
      entry_cnt[hit] = '0;
      entry_hi[hit] = price;
      entry_lo[hit] = price;
    end
    prod = ProdW'(price) * ProdW'(vol);
    pv_wide = PvWideW'(entry_pv[hit]) + PvWideW'(prod);
    entry_pv[hit] = (pv_wide >= PvWideW'(PvMax)) ? PvMax : pv_wide[PvW-1:0];
    vsum_wide = VsumWideW'(entry_vsum[hit]) + VsumWideW'(vol);
    entry_vsum[hit] = (vsum_wide >= VsumWideW'(VsumMax)) ? VsumMax : vsum_wide[VsumW-1:0];
    if (entry_cnt[hit] != CntMax) entry_cnt[hit] = entry_cnt[hit] + 1'b1;
    if (price > entry_hi[hit]) entry_hi[hit] = price;
    if (price < entry_lo[hit]) entry_lo[hit] = price;
    if (records != RecMax) records = records + 1'b1;
    r.slot = SlotW'(hit);
    r.pv   = entry_pv[hit];
    r.vsum = entry_vsum[hit];
    r.cnt  = entry_cnt[hit];
    r.hi   = entry_hi[hit];
    r.lo   = entry_lo[hit];
    r.rec  = records;
    r.sat  = (entry_pv[hit] == PvMax) || (entry_vsum[hit] == VsumMax);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_stats_t want;
    tick_stats_t predicted;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) entry_valid[i] = 1'b0;
      records = '0;
      expected_stats_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predicted = aggregate_tick(symbol_key_i, price_ticks_i, trade_volume_i);
        expected_stats_q = {expected_stats_q, predicted};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_stats_q.size() == 0) begin
          $error("result word with no tick pending");
          fail_count_o++;
        end else begin
          want = expected_stats_q[0];
          expected_stats_q.delete(0);
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("slot", 64'(want.slot), 64'(slot_i));
          check_field("price_volume_sum", 64'(want.pv), 64'(price_volume_sum_i));
          check_field("volume_sum", 64'(want.vsum), 64'(volume_sum_i));
          check_field("tick_count", 64'(want.cnt), 64'(tick_count_i));
          check_field("high_price", 64'(want.hi), 64'(high_price_i));
          check_field("low_price", 64'(want.lo), 64'(low_price_i));
          check_field("records_total", 64'(want.rec), 64'(records_total_i));
          check_field("sum_saturated", 64'(want.sat), 64'(sum_saturated_i));
        end
      end
    end
    pending_o <= expected_stats_q.size();
  end

endmodule

// ----- bench/tb_per_symbol_tick_aggregator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_per_symbol_tick_aggregator_unit
// Drives trade ticks into the aggregator: a directed set on field extremes,
// new/updated entries and high/low moves, a heavy-volume burst on one symbol
// with no idling, then random ticks over a key pool that later grows past the
// table size so that drops occur. Both sides idle at random otherwise.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_per_symbol_tick_aggregator_unit;
  import psta_pkg::*;

  localparam int ENTRIES      = TableEntriesDef;
  localparam int POOL_KEYS    = 40;
  localparam int HOT_TICKS    = 200;
  localparam int POOL_TICKS   = 700;
  localparam int MIXED_TICKS  = 850;
  localparam int DRAIN_CYCLES = ENTRIES + 40;
  localparam int IDLE_LIMIT   = 5000;

  localparam logic [KeyW-1:0] KeyMin = 64'h1;
  localparam logic [KeyW-1:0] KeyMax = '1;
  localparam logic [KeyW-1:0] KeyMsb = 64'h8000_0000_0000_0000;
  localparam logic [KeyW-1:0] KeyIbm = 64'h4942_4D00_0000_0000;
  localparam logic [KeyW-1:0] KeyHot = 64'h564F_4C48_4F54_0000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic [KeyW-1:0]   symbol_key_i = '0;
  logic [PriceW-1:0] price_ticks_i = '0;
  logic [VolW-1:0]   trade_volume_i = '0;
  logic              out_stall_i = 1'b0;
  logic              quiet = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [1:0]        status_o;
  logic [SlotW-1:0]  slot_o;
  logic [PvW-1:0]    price_volume_sum_o;
  logic [VsumW-1:0]  volume_sum_o;
  logic [CntW-1:0]   tick_count_o;
  logic [PriceW-1:0] high_price_o;
  logic [PriceW-1:0] low_price_o;
  logic [RecW-1:0]   records_total_o;
  logic              sum_saturated_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  logic [KeyW-1:0] pool_keys [POOL_KEYS];
  logic [KeyW-1:0] fresh_keys [$];

  per_symbol_tick_aggregator_unit #(.TABLE_ENTRIES(ENTRIES)) DUT (.*);

  tick_stats_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .symbol_key_i       (symbol_key_i),
    .price_ticks_i      (price_ticks_i),
    .trade_volume_i     (trade_volume_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_i           (status_o),
    .slot_i             (slot_o),
    .price_volume_sum_i (price_volume_sum_o),
    .volume_sum_i       (volume_sum_o),
    .tick_count_i       (tick_count_o),
    .high_price_i       (high_price_o),
    .low_price_i        (low_price_o),
    .records_total_i    (records_total_o),
    .sum_saturated_i    (sum_saturated_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 25);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] k;
    do k = {$urandom, $urandom}; while (k == '0);
    return k;
  endfunction

  function automatic logic [PriceW-1:0] random_price();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(2000000, 1000000);
    endcase
  endfunction

  function automatic logic [VolW-1:0] random_volume();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(5000, 1);
    endcase
  endfunction

  task automatic send_tick(input logic [KeyW-1:0] key, input logic [PriceW-1:0] price,
                           input logic [VolW-1:0] vol);
    while (!quiet && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    symbol_key_i   <= key;
    price_ticks_i  <= price;
    trade_volume_i <= vol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    logic [KeyW-1:0] key;
    int pick;
    foreach (pool_keys[i]) pool_keys[i] = random_key();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, create vs update, high/low moves, product saturation
    send_tick(KeyMin, '0, '0);
    send_tick(KeyMax, '1, '1);
    send_tick(KeyMax, '0, 32'd1);
    send_tick(KeyMin, 32'd5000, 32'd10);
    send_tick(KeyMin, '1, '0);
    send_tick(KeyMsb, 32'd1, '1);
    send_tick(KeyIbm, 32'd1500000, 32'd100);
    send_tick(KeyIbm, 32'd1400000, 32'd200);
    send_tick(KeyIbm, 32'd1600000, 32'd300);
    send_tick(KeyIbm, 32'd1500000, 32'd400);
    send_tick(KeyIbm, 32'd1400000, '0);
    send_tick(KeyMsb, 32'hAAAA_AAAA, 32'h5555_5555);
    send_tick(KeyMsb, 32'h5555_5555, 32'hAAAA_AAAA);
    send_tick(64'h5555_5555_5555_5555, '1, 32'd1);
    send_tick(64'hAAAA_AAAA_AAAA_AAAA, 32'd1, '1);

    // heavy-volume burst on one symbol, no idling on either side
    quiet <= 1'b1;
    for (int n = 0; n < HOT_TICKS; n++) send_tick(KeyHot, $urandom_range(3), '1);
    quiet <= 1'b0;

    // random ticks over a fixed symbol pool that fits in the table
    for (int n = 0; n < POOL_TICKS; n++)
      send_tick(pool_keys[$urandom_range(POOL_KEYS - 1)], random_price(), random_volume());

    // pool plus new symbols: the table fills and later new symbols are dropped
    for (int n = 0; n < MIXED_TICKS; n++) begin
      pick = $urandom_range(99);
      if (pick < 60 || fresh_keys.size() == 0 && pick < 75) begin
        key = pool_keys[$urandom_range(POOL_KEYS - 1)];
      end else if (pick < 75) begin
        key = fresh_keys[$urandom_range(fresh_keys.size() - 1)];
      end else begin
        key = random_key();
        fresh_keys = {fresh_keys, key};
      end
      send_tick(key, random_price(), random_volume());
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
